>>> hdl/jac_pkg.sv
// Package for the joystick axis conditioner.
// Holds register codes, reset values, the sequencer state type and the lane control struct.
// Used by jac_lane and joystick_axis_conditioner; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package jac_pkg;

	localparam int SAMPLE_BITS_DEFAULT = 12;

	localparam int GAIN_W   = 18;
	localparam int DZ_W     = 15;
	localparam int ALPHA_W  = 16;
	localparam int OFFSET_W = 14;
	localparam int ANGLE_W  = 17;
	localparam int AVG_W    = 24;
	localparam int CFG_W    = 18;
	localparam int OUT_W    = ((2 * ANGLE_W + 7) / 8) * 8;

	localparam int CENTER_RESET  = 2048;
	localparam int GAIN_RESET    = 72836;
	localparam int DZ_RESET      = 655;
	localparam int ALPHA_RESET   = 5243;
	localparam int OFFSET_H_RESET = 1536;
	localparam int OFFSET_V_RESET = 1280;

	typedef enum logic [2:0] {
		REG_CENTER_H = 3'd0,
		REG_CENTER_V = 3'd1,
		REG_GAIN_H   = 3'd2,
		REG_GAIN_V   = 3'd3,
		REG_DEADZONE = 3'd4,
		REG_ALPHA    = 3'd5,
		REG_OFFSET_H = 3'd6,
		REG_OFFSET_V = 3'd7
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SAT,
		ST_EMA,
		ST_UPD,
		ST_EMIT
	} seq_state_t;

	typedef struct packed {
		logic mul;
		logic sat;
		logic ema;
		logic upd;
		logic load;
	} lane_ctrl_t;

endpackage

`default_nettype wire

>>> hdl/joystick_axis_conditioner.sv
// An accepted item goes through the lane registers and the output register to m_axis.
// A new item is taken only in idle or as the emit step ends; the sequence walks each
// lane through its gain multiplier, saturation, EMA multiplier and average register.
// A held item (tuser set) updates the averages and gives no result.
// Reset (arst_n low) restores register defaults, clears the averages and the primed flag.
`timescale 1ns / 1ps
`default_nettype none

module joystick_axis_conditioner #(
	parameter int SAMPLE_BITS = jac_pkg::SAMPLE_BITS_DEFAULT,
	localparam int IN_W = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_axis_tvalid,
	output logic                              s_axis_tready,
	input  wire logic [IN_W-1:0]              s_axis_tdata,  // sample_horizontal, sample_vertical
	input  wire logic                         s_axis_tuser,  // hold
	output logic                              m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	output logic [jac_pkg::OUT_W-1:0]         m_axis_tdata,  // angle_x, angle_y
	input  wire logic                         wr_en,
	input  wire logic [2:0]                   wr_index,
	input  wire logic [jac_pkg::CFG_W-1:0]    wr_data
);

	import jac_pkg::*;

	logic [SAMPLE_BITS-1:0]        center_h_q;
	logic [SAMPLE_BITS-1:0]        center_v_q;
	logic [GAIN_W-1:0]             gain_h_q;
	logic [GAIN_W-1:0]             gain_v_q;
	logic [DZ_W-1:0]               deadzone_q;
	logic [ALPHA_W-1:0]            alpha_q;
	logic signed [OFFSET_W-1:0]    offset_h_q;
	logic signed [OFFSET_W-1:0]    offset_v_q;

	seq_state_t                    state_q;
	seq_state_t                    state_d;
	logic                          hold_q;
	logic                          primed_q;
	logic                          in_fire;
	logic                          emit_done;
	logic                          load_out;
	lane_ctrl_t                    ctrl;
	logic signed [ANGLE_W-1:0]     angle_h;
	logic signed [ANGLE_W-1:0]     angle_v;
	logic signed [ANGLE_W-1:0]     angle_x_q;
	logic signed [ANGLE_W-1:0]     angle_y_q;
	logic                          out_valid_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_h_q <= SAMPLE_BITS'(CENTER_RESET);
			center_v_q <= SAMPLE_BITS'(CENTER_RESET);
			gain_h_q   <= GAIN_W'(GAIN_RESET);
			gain_v_q   <= GAIN_W'(GAIN_RESET);
			deadzone_q <= DZ_W'(DZ_RESET);
			alpha_q    <= ALPHA_W'(ALPHA_RESET);
			offset_h_q <= OFFSET_W'(OFFSET_H_RESET);
			offset_v_q <= OFFSET_W'(OFFSET_V_RESET);
		end else if (wr_en) begin
			case (reg_index_t'(wr_index))
				REG_CENTER_H: center_h_q <= wr_data[SAMPLE_BITS-1:0];
				REG_CENTER_V: center_v_q <= wr_data[SAMPLE_BITS-1:0];
				REG_GAIN_H:   gain_h_q   <= wr_data[GAIN_W-1:0];
				REG_GAIN_V:   gain_v_q   <= wr_data[GAIN_W-1:0];
				REG_DEADZONE: deadzone_q <= wr_data[DZ_W-1:0];
				REG_ALPHA:    alpha_q    <= wr_data[ALPHA_W-1:0];
				REG_OFFSET_H: offset_h_q <= $signed(wr_data[OFFSET_W-1:0]);
				REG_OFFSET_V: offset_v_q <= $signed(wr_data[OFFSET_W-1:0]);
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign emit_done = hold_q || !out_valid_q || m_axis_tready;
	assign in_fire   = s_axis_tvalid && s_axis_tready;

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		load_out      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = ST_SAT;
				end
			end
			ST_SAT: state_d = ST_EMA;
			ST_EMA: state_d = ST_UPD;
			ST_UPD: state_d = ST_EMIT;
			ST_EMIT: begin
				if (emit_done) begin
					s_axis_tready = 1'b1;
					load_out      = !hold_q;
					state_d       = s_axis_tvalid ? ST_SAT : ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			hold_q <= s_axis_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= 1'b0;
		end else if (state_q == ST_UPD) begin
			primed_q <= 1'b1;
		end
	end

	assign ctrl.mul  = in_fire;
	assign ctrl.sat  = (state_q == ST_SAT);
	assign ctrl.ema  = (state_q == ST_EMA);
	assign ctrl.upd  = (state_q == ST_UPD);
	assign ctrl.load = !primed_q;

	jac_lane #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_lane_h (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.sample   (s_axis_tdata[SAMPLE_BITS-1:0]),
		.center   (center_h_q),
		.gain     (gain_h_q),
		.deadzone (deadzone_q),
		.alpha    (alpha_q),
		.offset   (offset_h_q),
		.angle    (angle_h)
	);

	jac_lane #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_lane_v (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.sample   (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
		.center   (center_v_q),
		.gain     (gain_v_q),
		.deadzone (deadzone_q),
		.alpha    (alpha_q),
		.offset   (offset_v_q),
		.angle    (angle_v)
	);

	// merge both lanes into the output register
	always_ff @(posedge clk) begin
		if (load_out) begin
			angle_x_q <= angle_h;
			angle_y_q <= angle_v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_W - 2 * ANGLE_W)'(0), angle_y_q, angle_x_q};

`ifndef ASSERT_OFF
	a_rise_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == ST_EMIT))
		else $error("result appeared outside the emit step");

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SAT || state_q == ST_EMA || state_q == ST_UPD) |-> !s_axis_tready)
		else $error("input taken while an item is in the lanes");

	a_upd_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) |=> (state_q == ST_EMIT && primed_q))
		else $error("average update not followed by emit");

	a_primed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		primed_q |=> primed_q)
		else $error("primed flag dropped");
`endif

endmodule

`default_nettype wire

>>> hdl/jac_lane.sv
// One axis lane: centre and gain multiply, saturation and deadzone, EMA update, angle.
// Steps are strobed by the sequencer in the top level through a lane_ctrl_t.
// Depends on jac_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jac_lane #(
	parameter int SAMPLE_BITS = jac_pkg::SAMPLE_BITS_DEFAULT
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire jac_pkg::lane_ctrl_t                   ctrl,
	input  wire logic [SAMPLE_BITS-1:0]                sample,
	input  wire logic [SAMPLE_BITS-1:0]                center,
	input  wire logic [jac_pkg::GAIN_W-1:0]            gain,
	input  wire logic [jac_pkg::DZ_W-1:0]              deadzone,
	input  wire logic [jac_pkg::ALPHA_W-1:0]           alpha,
	input  wire logic signed [jac_pkg::OFFSET_W-1:0]   offset,
	output logic signed [jac_pkg::ANGLE_W-1:0]         angle
);

	import jac_pkg::*;

	localparam int DW  = SAMPLE_BITS + 1;
	localparam int PW  = DW + GAIN_W + 1;
	localparam int EW  = AVG_W + 1;
	localparam int E2W = EW + ALPHA_W + 1;

	localparam logic signed [PW-1:0] SAT_HI = PW'(32767);
	localparam logic signed [PW-1:0] SAT_LO = PW'(-32768);

	logic signed [DW-1:0]  diff;
	logic signed [PW-1:0]  prod_s1;
	logic signed [PW-1:0]  scaled;
	logic signed [15:0]    d_sat;
	logic signed [16:0]    d_ext;
	logic        [16:0]    mag;
	logic        [15:0]    pos;
	logic        [AVG_W-1:0] target_s2;
	logic signed [EW-1:0]  delta;
	logic signed [E2W-1:0] prod_s3;
	logic signed [E2W-1:0] step;
	logic        [AVG_W-1:0] avg_q;
	logic        [31:0]    avg_deg;

	assign diff = $signed({1'b0, sample}) - $signed({1'b0, center});

	always_ff @(posedge clk) begin
		if (ctrl.mul) begin
			prod_s1 <= PW'(diff) * PW'($signed({1'b0, gain}));
		end
	end

	// floor of the Q1.15 deflection, then clamp to 16 bits
	assign scaled = prod_s1 >>> 12;

	always_comb begin
		if (scaled > SAT_HI) begin
			d_sat = 16'sh7FFF;
		end else if (scaled < SAT_LO) begin
			d_sat = -16'sh8000;
		end else begin
			d_sat = scaled[15:0];
		end
	end

	assign d_ext = 17'(d_sat);
	assign mag   = d_ext[16] ? 17'(-d_ext) : 17'(d_ext);
	// flip the sign bit to move to unsigned Q0.16; deadzone forces mid-scale
	assign pos   = (mag < {2'b00, deadzone}) ? 16'h8000 : (d_sat ^ 16'sh8000);

	always_ff @(posedge clk) begin
		if (ctrl.sat) begin
			target_s2 <= {pos, 8'h00};
		end
	end

	assign delta = $signed({1'b0, target_s2}) - $signed({1'b0, avg_q});

	always_ff @(posedge clk) begin
		if (ctrl.ema) begin
			prod_s3 <= E2W'(delta) * E2W'($signed({1'b0, alpha}));
		end
	end

	assign step = prod_s3 >>> 16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q <= '0;
		end else if (ctrl.upd) begin
			avg_q <= ctrl.load ? target_s2 : avg_q + step[AVG_W-1:0];
		end
	end

	assign avg_deg = {8'h00, avg_q} * 32'd180;
	assign angle   = $signed({1'b0, avg_deg[31:16]}) + ANGLE_W'(offset);

endmodule

`default_nettype wire
